### rtl/mpr_pkg.sv
// Shared widths, types and register codes of the MED prediction block.
package mpr_pkg;

  localparam int SampleInW     = 10;
  localparam int SampleOutW    = 9;
  localparam int FrameWidthW   = 11;
  localparam int FrameHeightW  = 16;
  localparam int ChannelCountW = 2;
  localparam int ChanEffW      = ChannelCountW + 1;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 16;
  localparam int PixelMax      = 255;

  typedef logic [7:0] pixel_t;
  typedef logic signed [SampleInW-1:0]  sample_in_t;
  typedef logic signed [SampleOutW-1:0] sample_out_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_DECODE_MODE   = 2'd3
  } cfg_reg_e;

endpackage

### rtl/mpr_if.sv
// Stream and configuration channel interfaces of the MED prediction block.
interface mpr_in_if import mpr_pkg::*; ();
  logic       valid;
  logic       ready;
  sample_in_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface mpr_out_if import mpr_pkg::*; ();
  logic        valid;
  logic        ready;
  sample_out_t sample_out;
  logic        end_of_image;

  modport source (output valid, output sample_out, output end_of_image, input ready);
  modport sink   (input valid, input sample_out, input end_of_image, output ready);
endinterface

interface mpr_cfg_if import mpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/mpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 3072,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mpr_med.sv
// Median edge detector prediction plus residual / reconstruction datapath.
module mpr_med import mpr_pkg::*; (
  input  pixel_t      a_i,
  input  pixel_t      b_i,
  input  pixel_t      c_i,
  input  sample_in_t  raw_i,
  input  logic        decode_i,
  output pixel_t      pix_o,
  output sample_out_t sample_out_o
);

  pixel_t              lo, hi, pred;
  logic signed [9:0]   grad;
  logic signed [10:0]  recon;
  pixel_t              pix_enc, pix_dec;

  // MED predictor: min/max on edges, planar gradient otherwise
  always_comb begin
    lo   = (a_i < b_i) ? a_i : b_i;
    hi   = (a_i < b_i) ? b_i : a_i;
    grad = $signed({2'b00, a_i}) + $signed({2'b00, b_i}) - $signed({2'b00, c_i});
    if (c_i >= hi) begin
      pred = lo;
    end else if (c_i <= lo) begin
      pred = hi;
    end else begin
      pred = grad[7:0];
    end
  end

  // encode: saturate the incoming pixel to 0..255
  always_comb begin
    if (raw_i < 0) begin
      pix_enc = '0;
    end else if (raw_i > SampleInW'(PixelMax)) begin
      pix_enc = pixel_t'(PixelMax);
    end else begin
      pix_enc = raw_i[7:0];
    end
  end

  // decode: prediction plus residual, clamped to 0..255
  always_comb begin
    recon = $signed({3'b000, pred}) + $signed({raw_i[SampleInW-1], raw_i});
    if (recon < 0) begin
      pix_dec = '0;
    end else if (recon > 11'sd255) begin
      pix_dec = pixel_t'(PixelMax);
    end else begin
      pix_dec = recon[7:0];
    end
  end

  always_comb begin
    if (decode_i) begin
      pix_o        = pix_dec;
      sample_out_o = $signed({1'b0, pix_dec});
    end else begin
      pix_o        = pix_enc;
      sample_out_o = $signed({1'b0, pix_enc}) - $signed({1'b0, pred});
    end
  end

endmodule

### rtl/med_predict_residual.sv
// MED (median edge detector) prediction stage: pixels to residuals or back.
// The block takes one sample per clock while the output side accepts results,
// in raster order with channels interleaved, and returns one result per sample
// through the stage 1 and output registers. Each sample reads its upper neighbor
// from a row store RAM in the transfer cycle and writes its pixel back when it
// leaves stage 1; a write and a read of one entry in one cycle (one-pixel-wide
// single-channel frames) are resolved by forwarding, so the rate stays at one
// sample per clock. Left and upper-left neighbors live in per-channel
// registers. A configuration write restarts the frame and must only be issued
// while the block is idle. end_of_image marks the last sample of a frame.
module med_predict_residual import mpr_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpr_cfg_if.sink   cfg_chan,
  mpr_in_if.sink    in_chan,
  mpr_out_if.source out_chan
);

  localparam int Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WeW   = ($clog2(MAX_WIDTH + 1) > FrameWidthW) ?
                         $clog2(MAX_WIDTH + 1) : FrameWidthW;

  // configuration registers
  logic [FrameWidthW-1:0]   frame_width_q;
  logic [FrameHeightW-1:0]  frame_height_q;
  logic [ChannelCountW-1:0] channel_count_q;
  logic                     decode_mode_q;

  // position counters
  logic [ColW-1:0]         col_q, col_d;
  logic [FrameHeightW-1:0] row_q, row_d;
  logic [ChW-1:0]          ch_q, ch_d;
  logic [AddrW-1:0]        base_q, base_d;

  // stage 1: RAM data in flight
  logic             s1_valid_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [ChW-1:0]   s1_ch_q;
  logic             s1_xpos_q, s1_ypos_q, s1_last_q;
  sample_in_t       s1_raw_q;
  logic             fwd_q;
  pixel_t           fwd_data_q;

  // neighbor registers
  pixel_t left_q [MAX_CHANNELS];
  pixel_t ul_q   [MAX_CHANNELS];

  // output register
  logic        out_valid_q;
  sample_out_t out_sample_q;
  logic        out_eoi_q;

  logic             cfg_fire, in_fire, s1_adv;
  logic [WeW-1:0]   w_cfg_ext, w_eff;
  logic [FrameHeightW-1:0] h_eff;
  logic [ChanEffW-1:0]     ch_eff;
  logic             col_last, row_last, ch_last, last_item;
  logic [AddrW-1:0] rd_addr;
  pixel_t           rdata, b_mem, nb_a, nb_b, nb_c, pix;
  sample_out_t      res_sample;

  assign cfg_chan.ready = 1'b1;
  assign cfg_fire = cfg_chan.valid & cfg_chan.ready;

  // stage 1 moves on when the output register is free or being emptied
  assign s1_adv   = s1_valid_q & (~out_valid_q | out_chan.ready);
  assign in_chan.ready = ~s1_valid_q | s1_adv;
  assign in_fire  = in_chan.valid & in_chan.ready;

  // effective frame geometry: zero taken as one, saturated to the maxima
  always_comb begin
    w_cfg_ext = WeW'(frame_width_q);
    if (frame_width_q == '0) begin
      w_eff = WeW'(1);
    end else if (w_cfg_ext > WeW'(MAX_WIDTH)) begin
      w_eff = WeW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg_ext;
    end
    h_eff = (frame_height_q == '0) ? FrameHeightW'(1) : frame_height_q;
    if (channel_count_q == '0) begin
      ch_eff = ChanEffW'(1);
    end else if (ChanEffW'(channel_count_q) > ChanEffW'(MAX_CHANNELS)) begin
      ch_eff = ChanEffW'(MAX_CHANNELS);
    end else begin
      ch_eff = ChanEffW'(channel_count_q);
    end
  end

  assign col_last  = (WeW'(col_q) == w_eff - WeW'(1));
  assign row_last  = (row_q == h_eff - FrameHeightW'(1));
  assign ch_last   = (ChanEffW'(ch_q) == ch_eff - ChanEffW'(1));
  assign last_item = col_last & row_last & ch_last;
  assign rd_addr   = base_q + AddrW'(ch_q);

  // raster position advance
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ch_d   = ch_q;
    base_d = base_q;
    if (cfg_fire) begin
      col_d  = '0;
      row_d  = '0;
      ch_d   = '0;
      base_d = '0;
    end else if (in_fire) begin
      if (ch_last) begin
        ch_d = '0;
        if (col_last) begin
          col_d  = '0;
          base_d = '0;
          row_d  = row_last ? '0 : row_q + FrameHeightW'(1);
        end else begin
          col_d  = col_q + ColW'(1);
          base_d = base_q + AddrW'(MAX_CHANNELS);
        end
      end else begin
        ch_d = ch_q + ChW'(1);
      end
    end
  end

  mpr_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (pix),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // neighbors; zero outside the image
  assign b_mem = fwd_q ? fwd_data_q : rdata;
  assign nb_a  = s1_xpos_q ? left_q[s1_ch_q] : '0;
  assign nb_b  = s1_ypos_q ? b_mem : '0;
  assign nb_c  = (s1_xpos_q & s1_ypos_q) ? ul_q[s1_ch_q] : '0;

  mpr_med u_med (
    .a_i          (nb_a),
    .b_i          (nb_b),
    .c_i          (nb_c),
    .raw_i        (s1_raw_q),
    .decode_i     (decode_mode_q),
    .pix_o        (pix),
    .sample_out_o (res_sample)
  );

  // control state, counters, configuration and neighbor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= FrameWidthW'(1024);
      frame_height_q  <= FrameHeightW'(1);
      channel_count_q <= ChannelCountW'(1);
      decode_mode_q   <= 1'b0;
      col_q           <= '0;
      row_q           <= '0;
      ch_q            <= '0;
      base_q          <= '0;
      s1_valid_q      <= 1'b0;
      fwd_q           <= 1'b0;
      out_valid_q     <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_q[i] <= '0;
        ul_q[i]   <= '0;
      end
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ch_q   <= ch_d;
      base_q <= base_d;

      if (cfg_fire) begin
        unique case (cfg_reg_e'(cfg_chan.index))
          REG_FRAME_WIDTH:   frame_width_q   <= cfg_chan.data[FrameWidthW-1:0];
          REG_FRAME_HEIGHT:  frame_height_q  <= cfg_chan.data[FrameHeightW-1:0];
          REG_CHANNEL_COUNT: channel_count_q <= cfg_chan.data[ChannelCountW-1:0];
          REG_DECODE_MODE:   decode_mode_q   <= cfg_chan.data[0];
          default: ;
        endcase
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          left_q[i] <= '0;
          ul_q[i]   <= '0;
        end
      end else if (s1_adv) begin
        left_q[s1_ch_q] <= pix;
        ul_q[s1_ch_q]   <= nb_b;
      end

      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv & (s1_addr_q == rd_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q  <= rd_addr;
      s1_ch_q    <= ch_q;
      s1_xpos_q  <= (col_q != '0);
      s1_ypos_q  <= (row_q != '0);
      s1_raw_q   <= in_chan.sample_in;
      s1_last_q  <= last_item;
      fwd_data_q <= pix;
    end
    if (s1_adv) begin
      out_sample_q <= res_sample;
      out_eoi_q    <= s1_last_q;
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.sample_out   = out_sample_q;
  assign out_chan.end_of_image = out_eoi_q;

  // a stalled stage 1 must keep its RAM read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_fire)
    else $error("row store read issued while stage 1 is stalled");

  // the last sample of a frame wraps the position back to the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_item && !cfg_fire) |=> (col_q == '0 && row_q == '0 && ch_q == '0))
    else $error("position did not wrap after end of frame");

  // position stays inside the effective frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WeW'(col_q) < w_eff) && (ChanEffW'(ch_q) < ch_eff) && (row_q < h_eff))
    else $error("position counter outside the frame");

endmodule

### tb/tb_med_predict_residual.sv
`timescale 1ns / 1ps
// Self-checking testbench of the MED prediction block: directed and random frames, scored in order.
module tb_med_predict_residual import mpr_pkg::*; ();

  localparam int CycleLimit   = 1_000_000;
  localparam int MaxReports   = 10;
  localparam int MaxWidth     = 1024;
  localparam int MaxChannels  = 3;
  localparam int RowDepth     = MaxWidth * MaxChannels;
  localparam int SettleCycles = 4;
  localparam int WideItems    = 120;
  localparam int RandomItems  = 330;

  typedef struct packed {
    sample_out_t value;
    logic        last;
  } pixel_result_t;

  logic clk_i;
  logic rst_ni;

  mpr_cfg_if cfg_bus ();
  mpr_in_if  in_bus ();
  mpr_out_if out_bus ();

  med_predict_residual u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_chan(cfg_bus),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  // Predictor state: line store, neighbor registers, position and settings
  pixel_t                   line_buf  [RowDepth];
  pixel_t                   left_px   [MaxChannels];
  pixel_t                   upleft_px [MaxChannels];
  int unsigned              col_pos, chan_pos, row_pos;
  logic [FrameWidthW-1:0]   width_reg;
  logic [FrameHeightW-1:0]  height_reg;
  logic [ChannelCountW-1:0] chans_reg;
  logic                     decode_reg;

  pixel_result_t expected_q [$];
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left;

  int unsigned rx_cycle = 0;
  int unsigned rx_hold  = 0;
  int          rx_mode  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Effective frame geometry after zero and saturation handling
  function automatic int unsigned eff_width();
    int unsigned w;
    w = (width_reg == 0) ? 1 : width_reg;
    return (w > MaxWidth) ? MaxWidth : w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int unsigned eff_chans();
    int unsigned c;
    c = (chans_reg == 0) ? 1 : chans_reg;
    return (c > MaxChannels) ? MaxChannels : c;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < MaxChannels; i++) begin
      left_px[i]   = '0;
      upleft_px[i] = '0;
    end
    col_pos  = 0;
    chan_pos = 0;
    row_pos  = 0;
  endfunction

  // Median edge prediction of one sample, updates the predictor state
  function automatic pixel_result_t predict_sample(input sample_in_t s);
    int unsigned   w, h, ch, x, y, c, addr;
    int            raw, a, b, tl, lo, hi, p, pix, outv;
    pixel_result_t r;
    w  = eff_width();
    h  = eff_height();
    ch = eff_chans();
    if (col_pos >= w || chan_pos >= ch || row_pos >= h) restart_frame();
    x    = col_pos;
    y    = row_pos;
    c    = chan_pos;
    addr = x * MaxChannels + c;
    raw  = s;
    a  = (x > 0) ? int'(left_px[c]) : 0;
    b  = (y > 0) ? int'(line_buf[addr]) : 0;
    tl = (x > 0 && y > 0) ? int'(upleft_px[c]) : 0;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (tl >= hi) begin
      p = lo;
    end else if (tl <= lo) begin
      p = hi;
    end else begin
      p = a + b - tl;
    end
    pix = decode_reg ? p + raw : raw;
    pix = (pix < 0) ? 0 : ((pix > PixelMax) ? PixelMax : pix);
    outv = decode_reg ? pix : pix - p;
    upleft_px[c]   = b[7:0];
    left_px[c]     = pix[7:0];
    line_buf[addr] = pix[7:0];
    r.value = outv[SampleOutW-1:0];
    r.last  = (x == w - 1) && (y == h - 1) && (c == ch - 1);
    // raster advance, wrapping at the end of the frame
    chan_pos = c + 1;
    if (chan_pos >= ch) begin
      chan_pos = 0;
      col_pos  = x + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = (y + 1 >= h) ? 0 : y + 1;
      end
    end
    return r;
  endfunction

  function automatic sample_in_t random_sample();
    if ($urandom_range(0, 7) == 0) return sample_in_t'($urandom);
    if (decode_reg) return sample_in_t'(int'($urandom_range(0, 80)) - 40);
    return sample_in_t'($urandom_range(0, 255));
  endfunction

  // Field value with random junk above the register width now and then
  function automatic logic [CfgDataW-1:0] pad_field(input int unsigned field, input int bits);
    logic [CfgDataW-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom) : '0;
    return CfgDataW'(field) | (junk << bits);
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("%s", msg);
  endtask

  // One sample transfer; the sender runs in bursts with random gaps
  task automatic send_sample(input sample_in_t value);
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= value;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    expected_q.insert(expected_q.size(), predict_sample(value));
    burst_left--;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; any write restarts the frame
  task automatic write_register(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   width_reg  = value[FrameWidthW-1:0];
      REG_FRAME_HEIGHT:  height_reg = value[FrameHeightW-1:0];
      REG_CHANNEL_COUNT: chans_reg  = value[ChannelCountW-1:0];
      REG_DECODE_MODE:   decode_reg = value[0];
      default: ;
    endcase
    restart_frame();
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                           input logic [CfgDataW-1:0] ch, input logic [CfgDataW-1:0] mode);
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
    write_register(REG_CHANNEL_COUNT, ch);
    write_register(REG_DECODE_MODE, mode);
  endtask

  // Reset settings: one long encode row, input extremes and saturation
  task automatic test_reset_defaults();
    send_sample(-512);
    send_sample(511);
    send_sample(0);
    send_sample(255);
    send_sample(256);
    send_sample(-1);
    send_sample(128);
    send_sample(127);
    wait_idle();
  endtask

  // 3x3 grey encode frame hitting the min, max and gradient predictions
  task automatic test_med_branches();
    set_frame(3, 3, 1, 0);
    send_sample(10);
    send_sample(200);
    send_sample(50);
    send_sample(100);
    send_sample(20);
    send_sample(150);
    send_sample(255);
    send_sample(0);
    send_sample(255);
    wait_idle();
  endtask

  // Decode with reconstruction clamped at both ends
  task automatic test_decode_clamp();
    set_frame(2, 2, 1, 1);
    send_sample(511);
    send_sample(-512);
    send_sample(0);
    send_sample(-1);
    wait_idle();
  endtask

  // All-ones register data (width saturates) and all-zero data (1x1x1 frame)
  task automatic test_register_corners();
    set_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_sample(255);
    send_sample(0);
    send_sample(77);
    send_sample(-300);
    wait_idle();
    set_frame(0, 0, 0, 1);
    send_sample(5);
    send_sample(-3);
    send_sample(300);
    wait_idle();
  endtask

  // Widest colour frame: a long run of row 0 with no early row wrap or end of frame
  task automatic test_widest_frame();
    set_frame(16'h07FF, 2, 3, 0);
    for (int i = 0; i < WideItems; i++) send_sample(random_sample());
    wait_idle();
  endtask

  // Random small geometries, whole frames mostly, cut-off frames sometimes
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned first;
    cfg_reg_e    reg_idx;
    sent = 0;
    while (sent < RandomItems) begin
      wait_idle();
      first = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
        reg_idx = cfg_reg_e'((k + first) % 4);
        if ($urandom_range(0, 3) != 0) begin
          case (reg_idx)
            REG_FRAME_WIDTH: begin
              write_register(reg_idx, pad_field(($urandom_range(0, 9) == 0) ?
                             $urandom_range(0, 40) : $urandom_range(0, 6), FrameWidthW));
            end
            REG_FRAME_HEIGHT: write_register(reg_idx, CfgDataW'($urandom_range(0, 5)));
            REG_CHANNEL_COUNT: begin
              write_register(reg_idx, pad_field($urandom_range(0, 3), ChannelCountW));
            end
            default: write_register(reg_idx, pad_field($urandom_range(0, 1), 1));
          endcase
        end
      end
      n = eff_width() * eff_height() * eff_chans() * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > 150) n = 150;
      for (int unsigned i = 0; i < n; i++) begin
        send_sample(random_sample());
        sent++;
        if (i == n / 2 && $urandom_range(0, 5) == 0) wait_idle();
      end
    end
    wait_idle();
  endtask

  // Output stalls: stall-free, random, ready when the cycle counter is a multiple of three, or long holds
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= ($urandom_range(0, 9) > 2);
      2: out_bus.ready <= (rx_cycle % 3 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_bus.ready <= 1'b0;
        end else begin
          out_bus.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 16);
        end
      end
    endcase
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_output
    pixel_result_t exp_r;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result: sample_out=%0d end_of_image=%0b",
                               out_bus.sample_out, out_bus.end_of_image));
      end else begin
        exp_r = expected_q.pop_front();
        if (out_bus.sample_out !== exp_r.value) begin
          note_failure($sformatf("sample_out mismatch: expected %0d, got %0d",
                                 exp_r.value, out_bus.sample_out));
        end
        if (out_bus.end_of_image !== exp_r.last) begin
          note_failure($sformatf("end_of_image mismatch: expected %0b, got %0b",
                                 exp_r.last, out_bus.end_of_image));
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("med_predict_residual verification failed");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_FRAME_WIDTH;
    cfg_bus.data     = '0;
    out_bus.ready    = 1'b0;
    width_reg        = FrameWidthW'(MaxWidth);
    height_reg       = 1;
    chans_reg        = 1;
    decode_reg       = 1'b0;
    restart_frame();
    burst_left       = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_med_branches();
    test_decode_clamp();
    test_register_corners();
    test_widest_frame();
    test_random_frames();

    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("med_predict_residual verification clean");
    end else begin
      $display("med_predict_residual verification failed");
    end
    $finish;
  end

endmodule
